### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/kmm_pkg.sv
// ----------------------------------------------------------------------------
// kmm_pkg
// Types and constants of the k-mismatch pattern match counter.
// ----------------------------------------------------------------------------
package kmm_pkg;

   localparam int OP_WIDTH        = 2;
   localparam int SYMBOL_WIDTH    = 8;
   localparam int LIMIT_WIDTH     = 6;
   localparam int MISMATCH_WIDTH  = 6;
   localparam int TOTAL_OUT_WIDTH = 32;
   localparam int MISMATCH_MAX    = (1 << MISMATCH_WIDTH) - 1;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int TOTAL_WIDTH_DEF = 32;

   // Depth of the command queue; a power of two so the pointers wrap.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic                    has_result;
      logic [SYMBOL_WIDTH-1:0] symbol;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } stage_type;

endpackage

### sv/kmm_if.sv
// ----------------------------------------------------------------------------
// kmm interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kmm_req_if;
   import kmm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_WIDTH-1:0]     operation;
   logic [SYMBOL_WIDTH-1:0] symbol;

   modport source (output valid, output operation, output symbol, input ready);
   modport sink   (input valid, input operation, input symbol, output ready);
endinterface

interface kmm_rsp_if;
   import kmm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       window_match;
   logic [MISMATCH_WIDTH-1:0]  window_mismatches;
   logic [TOTAL_OUT_WIDTH-1:0] match_total;

   modport source (output valid, output window_match, output window_mismatches,
                   output match_total, input ready);
   modport sink   (input valid, input window_match, input window_mismatches,
                   input match_total, output ready);
endinterface

interface kmm_csr_if;
   import kmm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LIMIT_WIDTH-1:0] mismatch_limit;

   modport source (output valid, output mismatch_limit, input ready);
   modport sink   (input valid, input mismatch_limit, output ready);
endinterface

### sv/k_mismatch_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// k_mismatch_pattern_match_counter
// A text request passes the front register, the command queue and the
// response register. One request per cycle unless responses stall; the
// back engine updates all alignment counters at once from a two-entry queue.
// Reset (synchronous) empties the pattern, counters, match total and limit.
// ----------------------------------------------------------------------------
module k_mismatch_pattern_match_counter #(
   parameter int MAX_PATTERN = kmm_pkg::MAX_PATTERN_DEF,
   parameter int TOTAL_WIDTH = kmm_pkg::TOTAL_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   kmm_req_if.sink    req_bus,
   kmm_rsp_if.source  rsp_bus,
   kmm_csr_if.sink    csr_bus
);
   import kmm_pkg::*;

   stage_type push;
   stage_type head;
   logic      push_ready;
   logic      head_ready;

   kmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   kmm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .head_ready (head_ready)
   );

   kmm_back #(
      .MAX_PATTERN (MAX_PATTERN),
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_ready (head_ready),
      .csr_bus    (csr_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule

### sv/kmm_front.sv
// ----------------------------------------------------------------------------
// kmm_front
// Accepts requests, decodes the operation and holds one decoded command.
// ----------------------------------------------------------------------------
module kmm_front (
   input  logic                clock,
   input  logic                reset,
   kmm_req_if.sink             req_bus,
   output kmm_pkg::stage_type  push,
   input  logic                push_ready
);
   import kmm_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;

   always_comb begin
      req_bus.ready = !valid_ff || push_ready;
      take          = req_bus.valid && req_bus.ready;

      cmd_in            = cmd_ff;
      cmd_in.op         = op_type'(req_bus.operation);
      cmd_in.has_result = (op_type'(req_bus.operation) == OP_TEXT);
      cmd_in.symbol     = req_bus.symbol;
      if (!take) begin
         cmd_in = cmd_ff;
      end

      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      push.valid = valid_ff;
      push.cmd   = cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

### sv/kmm_queue.sv
// ----------------------------------------------------------------------------
// kmm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module kmm_queue (
   input  logic                clock,
   input  logic                reset,
   input  kmm_pkg::stage_type  push,
   output logic                push_ready,
   output kmm_pkg::stage_type  head,
   input  logic                head_ready
);
   import kmm_pkg::*;

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
      head.valid = (count_ff != '0);
      head.cmd   = entries_ff[rd_ptr_ff];

      do_push = push.valid && push_ready;
      do_pop  = head.valid && head_ready;

      wr_ptr_in = do_push ? QUEUE_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = QUEUE_CNT_W'(count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

### sv/kmm_back.sv
// ----------------------------------------------------------------------------
// kmm_back
// Shift-add engine: pattern store, alignment counters, match total and the
// response register.
// ----------------------------------------------------------------------------
module kmm_back #(
   parameter int MAX_PATTERN = kmm_pkg::MAX_PATTERN_DEF,
   parameter int TOTAL_WIDTH = kmm_pkg::TOTAL_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  kmm_pkg::stage_type  head,
   output logic                head_ready,
   kmm_csr_if.sink             csr_bus,
   kmm_rsp_if.source           rsp_bus
);
   import kmm_pkg::*;

   localparam int CW   = $clog2(MAX_PATTERN + 1);
   localparam int IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int CMPW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;

   logic [SYMBOL_WIDTH-1:0]    pat_ff [MAX_PATTERN];
   logic [CW-1:0]              cnt_ff [MAX_PATTERN];
   logic [CW-1:0]              cnt_in [MAX_PATTERN];
   logic [CW-1:0]              cnt_next [MAX_PATTERN];
   logic [CW-1:0]              len_ff, len_in;
   logic [CW-1:0]              seen_ff, seen_in;
   logic [CW-1:0]              seen_step;
   logic [IW-1:0]              last_ff, last_in;
   logic                       overlong_ff, overlong_in;
   logic [TOTAL_WIDTH-1:0]     total_ff, total_in;
   logic [LIMIT_WIDTH-1:0]     limit_ff, limit_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       match_ff, match_in;
   logic [MISMATCH_WIDTH-1:0]  mism_ff, mism_in;
   logic [TOTAL_OUT_WIDTH-1:0] mtotal_ff, mtotal_in;

   logic                       take, pat_we, usable, full, hit;
   logic [CW-1:0]              count;

   always_comb begin
      head_ready = !head.cmd.has_result || !rsp_valid_ff || rsp_bus.ready;
      take       = head.valid && head_ready;

      csr_bus.ready = 1'b1;
      limit_in      = csr_bus.valid ? csr_bus.mismatch_limit : limit_ff;

      // Every alignment advances by one text position at once.
      cnt_next[0] = CW'(head.cmd.symbol != pat_ff[0]);
      for (int j = 1; j < MAX_PATTERN; j++) begin
         cnt_next[j] = CW'(cnt_ff[j-1] + CW'(head.cmd.symbol != pat_ff[j]));
      end

      usable    = (len_ff != '0) && !overlong_ff;
      seen_step = (seen_ff < len_ff) ? CW'(seen_ff + 1'b1) : seen_ff;
      full      = (seen_step >= len_ff);
      count     = cnt_next[last_ff];
      hit       = full && (CMPW'(count) <= CMPW'(limit_ff));

      len_in      = len_ff;
      seen_in     = seen_ff;
      last_in     = last_ff;
      overlong_in = overlong_ff;
      total_in    = total_ff;
      pat_we      = 1'b0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         cnt_in[j] = cnt_ff[j];
      end

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      match_in     = match_ff;
      mism_in      = mism_ff;
      mtotal_in    = mtotal_ff;

      if (take) begin
         unique case (head.cmd.op)
            OP_CLEAR: begin
               len_in      = '0;
               last_in     = '0;
               overlong_in = 1'b0;
               seen_in     = '0;
               total_in    = '0;
               for (int j = 0; j < MAX_PATTERN; j++) begin
                  cnt_in[j] = '0;
               end
            end
            OP_APPEND: begin
               if (len_ff < CW'(MAX_PATTERN)) begin
                  pat_we  = 1'b1;
                  len_in  = CW'(len_ff + 1'b1);
                  last_in = len_ff[IW-1:0];
               end else begin
                  overlong_in = 1'b1;
               end
               seen_in = '0;
               for (int j = 0; j < MAX_PATTERN; j++) begin
                  cnt_in[j] = '0;
               end
            end
            OP_TEXT: begin
               rsp_valid_in = 1'b1;
               match_in     = 1'b0;
               mism_in      = '0;
               mtotal_in    = TOTAL_OUT_WIDTH'(total_ff);
               // With no usable pattern the window state is left untouched.
               if (usable) begin
                  seen_in = seen_step;
                  for (int j = 0; j < MAX_PATTERN; j++) begin
                     cnt_in[j] = cnt_next[j];
                  end
                  if (full) begin
                     match_in = hit;
                     mism_in  = (CMPW'(count) > CMPW'(MISMATCH_MAX)) ?
                                MISMATCH_WIDTH'(MISMATCH_MAX) : MISMATCH_WIDTH'(count);
                     if (hit && (total_ff != '1)) begin
                        total_in  = TOTAL_WIDTH'(total_ff + 1'b1);
                        mtotal_in = TOTAL_OUT_WIDTH'(total_in);
                     end
                  end
               end
            end
            OP_RESTART: begin
               seen_in  = '0;
               total_in = '0;
               for (int j = 0; j < MAX_PATTERN; j++) begin
                  cnt_in[j] = '0;
               end
            end
         endcase
      end

      rsp_bus.valid             = rsp_valid_ff;
      rsp_bus.window_match      = match_ff;
      rsp_bus.window_mismatches = mism_ff;
      rsp_bus.match_total       = mtotal_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         seen_ff      <= '0;
         last_ff      <= '0;
         overlong_ff  <= 1'b0;
         total_ff     <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         last_ff      <= last_in;
         overlong_ff  <= overlong_in;
         total_ff     <= total_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            cnt_ff[j] <= cnt_in[j];
         end
      end
      match_ff  <= match_in;
      mism_ff   <= mism_in;
      mtotal_ff <= mtotal_in;
      if (pat_we) begin
         pat_ff[len_ff[IW-1:0]] <= head.cmd.symbol;
      end
   end

endmodule

### sv/kmm_checker.sv
// ----------------------------------------------------------------------------
// kmm_checker
// Port-level checks of the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmm_checker #(
   parameter int TOTAL_WIDTH = kmm_pkg::TOTAL_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                window_match,
   input logic [kmm_pkg::MISMATCH_WIDTH-1:0]  window_mismatches,
   input logic [kmm_pkg::TOTAL_OUT_WIDTH-1:0] match_total
);
   import kmm_pkg::*;

   // A stalled response stays offered.
   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // A stalled response keeps its payload.
   `ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && !rsp_ready, $stable(window_match) && $stable(window_mismatches) && $stable(match_total), "response payload changed while stalled")

   // A matching window has already been counted in the total.
   `ASSERT_IMPLIES(match_counted_a, clock, reset, rsp_valid && window_match, (TOTAL_WIDTH > TOTAL_OUT_WIDTH) || (match_total != '0), "match reported with zero total")

   // Nothing is offered right after reset.
   `ASSERT_NEXT(reset_quiet_a, clock, 1'b0, reset, !rsp_valid, "response valid after reset")

endmodule

bind k_mismatch_pattern_match_counter kmm_checker #(
   .TOTAL_WIDTH (TOTAL_WIDTH)
) u_kmm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .window_match      (rsp_bus.window_match),
   .window_mismatches (rsp_bus.window_mismatches),
   .match_total       (rsp_bus.match_total)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the k-mismatch pattern match counter. A short
// table of requests covers each operation and the corner cases. Random
// episodes follow: load a pattern, then stream text built from the pattern
// with controlled corruption. Each response is checked against a built-in
// window predictor under several mismatch limits and handshake pacing modes.
// ----------------------------------------------------------------------------
module tb_top;
   import kmm_pkg::*;

   localparam int PATTERN_SLOTS   = MAX_PATTERN_DEF;
   localparam int ITEMS_PER_PHASE = 40;
   localparam int PHASES          = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int SETTLE_CYCLES   = 10;
   localparam int DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic                       match;
      logic [MISMATCH_WIDTH-1:0]  mismatches;
      logic [TOTAL_OUT_WIDTH-1:0] total;
   } window_result_type;

   typedef struct packed {
      op_type                  op;
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic                    known;
      window_result_type       want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kmm_req_if req_bus ();
   kmm_rsp_if rsp_bus ();
   kmm_csr_if csr_bus ();

   k_mismatch_pattern_match_counter u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // Window predictor state.
   logic [SYMBOL_WIDTH-1:0]    pat_bytes [PATTERN_SLOTS];
   int                         pat_len;
   bit                         pat_overlong;
   logic [MISMATCH_WIDTH-1:0]  align_cnt [PATTERN_SLOTS];
   int                         text_seen;
   logic [TOTAL_OUT_WIDTH-1:0] run_total;
   logic [LIMIT_WIDTH-1:0]     limit_now;

   window_result_type expected_windows [$];

   int error_count     = 0;
   int items_sent      = 0;
   int text_sent       = 0;
   int results_seen    = 0;
   int matches_seen    = 0;
   int overlong_events = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;

   // Expected values are typed in where they are obvious; zero elsewhere.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_TEXT,    8'h00, 1'b1, '{1'b0, 6'd0, 32'd0}},  // empty pattern
      '{OP_TEXT,    8'hFF, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_APPEND,  8'h41, 1'b0, '0},
      '{OP_APPEND,  8'h42, 1'b0, '0},
      '{OP_APPEND,  8'h43, 1'b0, '0},
      '{OP_TEXT,    8'h41, 1'b1, '{1'b0, 6'd0, 32'd0}},  // partial window
      '{OP_TEXT,    8'h42, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_TEXT,    8'h43, 1'b1, '{1'b1, 6'd0, 32'd1}},  // exact hit
      '{OP_TEXT,    8'h41, 1'b0, '0},
      '{OP_TEXT,    8'h42, 1'b0, '0},
      '{OP_TEXT,    8'h43, 1'b1, '{1'b1, 6'd0, 32'd2}},
      '{OP_RESTART, 8'h00, 1'b0, '0},
      '{OP_TEXT,    8'h41, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_APPEND,  8'h44, 1'b0, '0},
      '{OP_TEXT,    8'h41, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_TEXT,    8'h42, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_TEXT,    8'h43, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_TEXT,    8'h00, 1'b0, '0},
      '{OP_CLEAR,   8'hFF, 1'b0, '0},
      '{OP_APPEND,  8'hFF, 1'b0, '0},
      '{OP_APPEND,  8'h00, 1'b0, '0},
      '{OP_TEXT,    8'h00, 1'b1, '{1'b0, 6'd0, 32'd0}},
      '{OP_TEXT,    8'hFF, 1'b0, '0},
      '{OP_TEXT,    8'h00, 1'b1, '{1'b1, 6'd0, 32'd1}},
      '{OP_TEXT,    8'h5A, 1'b0, '0}
   };

   int phase_limits [6] = '{32, 0, 1, 3, 31, 2};

   function automatic void clear_window();
      foreach (align_cnt[j]) align_cnt[j] = '0;
      text_seen = 0;
   endfunction

   // Applies one request to the predictor; returns 1 when a response follows.
   function automatic bit predict_window(input op_type op,
                                         input logic [SYMBOL_WIDTH-1:0] sym,
                                         output window_result_type res);
      int m;
      res = '0;
      case (op)
         OP_CLEAR: begin
            pat_len = 0;
            pat_overlong = 1'b0;
            clear_window();
            run_total = '0;
            return 1'b0;
         end
         OP_APPEND: begin
            if (pat_len < PATTERN_SLOTS) begin
               pat_bytes[pat_len] = sym;
               pat_len++;
            end else begin
               pat_overlong = 1'b1;
               overlong_events++;
            end
            clear_window();
            return 1'b0;
         end
         OP_RESTART: begin
            clear_window();
            run_total = '0;
            return 1'b0;
         end
         default: begin
         end
      endcase

      m = pat_len;
      if (m == 0 || pat_overlong) begin
         res.total = run_total;
         return 1'b1;
      end
      // Every alignment shifts one place along and adds its own comparison.
      for (int j = m - 1; j > 0; j--)
         align_cnt[j] = align_cnt[j-1] + MISMATCH_WIDTH'(sym != pat_bytes[j]);
      align_cnt[0] = MISMATCH_WIDTH'(sym != pat_bytes[0]);
      if (text_seen < m)
         text_seen++;
      if (text_seen >= m) begin
         res.mismatches = align_cnt[m-1];
         if (align_cnt[m-1] <= limit_now) begin
            res.match = 1'b1;
            if (run_total != '1)
               run_total++;
         end
      end
      res.total = run_total;
      return 1'b1;
   endfunction

   task automatic report_error(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      $display("ERROR at %0t: %s got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back requests never drop it.
   task automatic send_request(input op_type op, input logic [SYMBOL_WIDTH-1:0] sym,
                               input logic known, input window_result_type want);
      window_result_type predicted;
      bit                has_result;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = op;
      req_bus.symbol    = sym;
      do @(posedge clock); while (!req_bus.ready);
      has_result = predict_window(op, sym, predicted);
      if (has_result) begin
         expected_windows.push_back(known ? want : predicted);
         text_sent++;
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid = 1'b0;
      while (expected_windows.size() != 0)
         @(negedge clock);
      // Requests with no response may still be in the pipeline.
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
      csr_bus.valid          = 1'b1;
      csr_bus.mismatch_limit = value;
      do @(posedge clock); while (!csr_bus.ready);
      limit_now = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // One episode: one to four random requests, or optionally clear, load a
   // pattern, then stream shifted copies of it with a chosen share corrupted.
   task automatic run_episode(input int forced_len);
      int                      len;
      int                      roll;
      int                      mut_pct;
      int                      run_len;
      int                      offset;
      logic [SYMBOL_WIDTH-1:0] sym;
      roll = $urandom_range(99);
      if (forced_len == 0 && roll < 10) begin
         repeat ($urandom_range(1, 4))
            send_request(op_type'($urandom_range(3)), SYMBOL_WIDTH'($urandom_range(255)),
                         1'b0, '0);
         return;
      end
      if (forced_len != 0 || $urandom_range(3) != 0)
         send_request(OP_CLEAR, SYMBOL_WIDTH'($urandom_range(255)), 1'b0, '0);
      if (forced_len != 0) begin
         len = forced_len;
      end else begin
         roll = $urandom_range(99);
         if (roll < 70)
            len = $urandom_range(1, 6);
         else if (roll < 90)
            len = $urandom_range(7, 16);
         else if (roll < 97)
            len = $urandom_range(17, PATTERN_SLOTS);
         else
            len = $urandom_range(PATTERN_SLOTS + 1, PATTERN_SLOTS + 2);
      end
      repeat (len)
         send_request(OP_APPEND, SYMBOL_WIDTH'($urandom_range(255)), 1'b0, '0);
      case ($urandom_range(4))
         0: mut_pct = 0;
         1: mut_pct = 10;
         2: mut_pct = 30;
         3: mut_pct = 60;
         default: mut_pct = 100;
      endcase
      run_len = pat_len + $urandom_range(2, 2 * pat_len + 8);
      offset  = (pat_len > 1) ? $urandom_range(pat_len - 1) : 0;
      for (int i = 0; i < run_len; i++) begin
         if ($urandom_range(99) < 3)
            send_request(OP_RESTART, SYMBOL_WIDTH'($urandom_range(255)), 1'b0, '0);
         if (pat_len == 0) begin
            sym = SYMBOL_WIDTH'($urandom_range(255));
         end else begin
            sym = pat_bytes[(i + offset) % pat_len];
            if ($urandom_range(99) < mut_pct)
               sym ^= SYMBOL_WIDTH'($urandom_range(1, 255));
         end
         send_request(OP_TEXT, sym, 1'b0, '0);
      end
   endtask

   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.window_match)
            matches_seen++;
         if (expected_windows.size() == 0) begin
            report_error("response with no request outstanding, match_total",
                         rsp_bus.match_total, 32'd0);
         end else begin
            want = expected_windows.pop_front();
            if (rsp_bus.window_match !== want.match)
               report_error("window_match", 32'(rsp_bus.window_match), 32'(want.match));
            if (rsp_bus.window_mismatches !== want.mismatches)
               report_error("window_mismatches", 32'(rsp_bus.window_mismatches),
                            32'(want.mismatches));
            if (rsp_bus.match_total !== want.total)
               report_error("match_total", rsp_bus.match_total, want.total);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout with %0d responses outstanding", expected_windows.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase_start;
      bit paused;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_CLEAR;
      req_bus.symbol         = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.mismatch_limit = '0;
      foreach (pat_bytes[j]) pat_bytes[j] = '0;
      pat_len      = 0;
      pat_overlong = 1'b0;
      clear_window();
      run_total    = '0;
      limit_now    = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_limit('0);
      foreach (directed_rows[i])
         send_request(directed_rows[i].op, directed_rows[i].symbol,
                      directed_rows[i].known, directed_rows[i].want);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         write_limit(LIMIT_WIDTH'((p < 6) ? phase_limits[p] : $urandom_range(32)));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         phase_start = items_sent;
         paused      = 1'b0;
         // A full-length pattern under the largest limit, then an over-long one.
         if (p == 0)
            run_episode(PATTERN_SLOTS);
         if (p == 1)
            run_episode(PATTERN_SLOTS + 1);
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            run_episode(0);
            if (!paused && items_sent - phase_start >= ITEMS_PER_PHASE / 2) begin
               wait_idle();
               paused = 1'b1;
            end
         end
         wait_idle();
      end

      $display("Sent %0d requests (%0d text bytes) under %0d limit settings %s",
               items_sent, text_sent, PHASES + 1, "and four pacing modes.");
      $display("Checked %0d responses, %0d window matches, %0d over-long appends.",
               results_seen, matches_seen, overlong_events);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
